// ===== src/rfe_pkg.sv =====
`default_nettype none
package rfe_pkg;

	// Frame and CRC constants.
	localparam logic [15:0] CRC_INIT = 16'hd77f;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [7:0]  SOF_BYTE = 8'hfd;
	localparam logic [7:0]  ESC_BYTE = 8'hfc;
	localparam logic [7:0]  ESC_MASK = 8'h7f;
	localparam logic [16:0] HDR_OVERHEAD = 17'd8;
	localparam logic [15:0] LEN_OVERHEAD = 16'd3;
	localparam logic [15:0] MAX_RESET = 16'hffff;

	// Kinds of work item passed from the front to the back.
	localparam logic [2:0] OP_DATA = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_CRCH = 3'd2;
	localparam logic [2:0] OP_CRCL = 3'd3;
	localparam logic [2:0] OP_ERR = 3'd4;

	// Queue sizes.
	localparam int OPQ_AW = 2;
	localparam int OPQ_DEPTH = 4;
	localparam logic [OPQ_AW:0] OPQ_FULL_CNT = (OPQ_AW + 1)'(OPQ_DEPTH);
	localparam int OUTQ_AW = 2;
	localparam int OUTQ_DEPTH = 4;
	localparam logic [OUTQ_AW:0] OUTQ_FULL_CNT = (OUTQ_AW + 1)'(OUTQ_DEPTH);

	// One unescaped line byte job.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       esc;
		logic       last;
	} op_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       error;
	} res_t;

	// CRC-16 update over one byte, MSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/rfe_front.sv =====
`default_nettype none
module rfe_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic        cmd,
	input  wire logic [7:0]  destination,
	input  wire logic [7:0]  sequence_count,
	input  wire logic [7:0]  command_code,
	input  wire logic [15:0] payload_length,
	input  wire logic        escape_enable,
	input  wire logic [7:0]  data_byte,
	output logic             op_push,
	input  wire logic        op_full,
	output rfe_pkg::op_t     op_data
);
	import rfe_pkg::*;

	localparam logic [3:0] ST_START = 4'd0;
	localparam logic [3:0] ST_LENH = 4'd1;
	localparam logic [3:0] ST_LENL = 4'd2;
	localparam logic [3:0] ST_DST = 4'd3;
	localparam logic [3:0] ST_SEQ = 4'd4;
	localparam logic [3:0] ST_CMD = 4'd5;
	localparam logic [3:0] ST_DATA = 4'd6;
	localparam logic [3:0] ST_CRCH = 4'd7;
	localparam logic [3:0] ST_CRCL = 4'd8;
	localparam logic [3:0] ST_ERR = 4'd9;
	localparam logic [3:0] ST_IDLE = 4'd10;

	logic        busy_q;
	logic [3:0]  step_q;
	logic        frame_open_q;
	logic [15:0] bytes_left_q;
	logic [15:0] max_q;
	logic        esc_q;
	logic [15:0] lenf_q;
	logic [7:0]  dst_q;
	logic [7:0]  seq_q;
	logic [7:0]  code_q;
	logic [7:0]  dat_q;
	logic        tail_crc_q;

	logic [3:0]  nxt;
	logic        step_done;
	logic        last_step;
	logic        accept;
	logic        too_big;

	// Successor of the current step; ST_IDLE marks the end of the item.
	always_comb begin
		case (step_q)
			ST_START: nxt = ST_LENH;
			ST_LENH:  nxt = ST_LENL;
			ST_LENL:  nxt = ST_DST;
			ST_DST:   nxt = ST_SEQ;
			ST_SEQ:   nxt = ST_CMD;
			ST_CMD:   nxt = tail_crc_q ? ST_CRCH : ST_IDLE;
			ST_DATA:  nxt = tail_crc_q ? ST_CRCH : ST_IDLE;
			ST_CRCH:  nxt = ST_CRCL;
			default:  nxt = ST_IDLE;
		endcase
	end

	// Build the job for the current step.
	always_comb begin
		op_data.esc = esc_q;
		op_data.last = (nxt == ST_IDLE);
		case (step_q)
			ST_START: begin
				op_data.kind = OP_START;
				op_data.data = SOF_BYTE;
			end
			ST_LENH: begin
				op_data.kind = OP_DATA;
				op_data.data = lenf_q[15:8];
			end
			ST_LENL: begin
				op_data.kind = OP_DATA;
				op_data.data = lenf_q[7:0];
			end
			ST_DST: begin
				op_data.kind = OP_DATA;
				op_data.data = dst_q;
			end
			ST_SEQ: begin
				op_data.kind = OP_DATA;
				op_data.data = seq_q;
			end
			ST_CMD: begin
				op_data.kind = OP_DATA;
				op_data.data = code_q;
			end
			ST_DATA: begin
				op_data.kind = OP_DATA;
				op_data.data = dat_q;
			end
			ST_CRCH: begin
				op_data.kind = OP_CRCH;
				op_data.data = 8'h00;
			end
			ST_CRCL: begin
				op_data.kind = OP_CRCL;
				op_data.data = 8'h00;
			end
			default: begin
				op_data.kind = OP_ERR;
				op_data.data = 8'h00;
			end
		endcase
	end

	// Handshake: a new item is taken once the last job of the previous one goes out.
	assign step_done = busy_q && !op_full;
	assign last_step = (nxt == ST_IDLE);
	assign op_push = step_done;
	assign full = busy_q && !(step_done && last_step);
	assign accept = push && !full;
	assign too_big = ({1'b0, payload_length} + HDR_OVERHEAD) > {1'b0, max_q};

	// Control state and frame bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_START;
			frame_open_q <= 1'b0;
			bytes_left_q <= 16'd0;
			max_q <= MAX_RESET;
			esc_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (step_done) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= nxt;
				end
			end
			if (accept) begin
				if (!cmd) begin
					bytes_left_q <= too_big ? 16'd0 : payload_length;
					frame_open_q <= !too_big;
					busy_q <= 1'b1;
					step_q <= too_big ? ST_ERR : ST_START;
					if (!too_big) begin
						esc_q <= escape_enable;
					end
				end else if (frame_open_q && bytes_left_q != 16'd0) begin
					bytes_left_q <= bytes_left_q - 16'd1;
					if (bytes_left_q == 16'd1) begin
						frame_open_q <= 1'b0;
					end
					busy_q <= 1'b1;
					step_q <= ST_DATA;
				end
			end
		end
	end

	// Latched item fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!cmd) begin
				lenf_q <= payload_length + LEN_OVERHEAD;
				dst_q <= destination;
				seq_q <= sequence_count;
				code_q <= command_code;
				tail_crc_q <= (payload_length == 16'd0);
			end else begin
				dat_q <= data_byte;
				tail_crc_q <= (bytes_left_q == 16'd1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/rfe_op_queue.sv =====
`default_nettype none
module rfe_op_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire rfe_pkg::op_t push_data,
	output logic              full,
	input  wire logic         pop,
	output rfe_pkg::op_t      pop_data,
	output logic              empty
);
	import rfe_pkg::*;

	op_t               mem_q [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wptr_q;
	logic [OPQ_AW-1:0] rptr_q;
	logic [OPQ_AW:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == OPQ_FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== src/rfe_back.sv =====
`default_nettype none
module rfe_back (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    op_empty,
	input  wire rfe_pkg::op_t op_data,
	output logic         op_pop,
	input  wire logic    res_pop,
	output logic         res_empty,
	output rfe_pkg::res_t res
);
	import rfe_pkg::*;

	logic [15:0]        crc_q;
	logic               half_q;
	res_t               mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wptr_q;
	logic [OUTQ_AW-1:0] rptr_q;
	logic [OUTQ_AW:0]   cnt_q;

	logic [7:0] b;
	logic       escapable;
	logic       need_esc;
	logic       go;
	logic       out_pop;
	res_t       wr;

	// Raw byte for the job at the head of the queue.
	always_comb begin
		case (op_data.kind)
			OP_DATA:  b = op_data.data;
			OP_START: b = SOF_BYTE;
			OP_CRCH:  b = crc_q[15:8];
			OP_CRCL:  b = crc_q[7:0];
			default:  b = 8'h00;
		endcase
	end

	assign escapable = (op_data.kind == OP_DATA) || (op_data.kind == OP_CRCH) ||
		(op_data.kind == OP_CRCL);
	assign need_esc = op_data.esc && escapable && ((b == ESC_BYTE) || (b == SOF_BYTE));
	assign go = !op_empty && (cnt_q != OUTQ_FULL_CNT);
	assign op_pop = go && (half_q || !need_esc);
	assign out_pop = res_pop && !res_empty;

	// Line byte written this cycle: escape mark, escaped byte or plain byte.
	always_comb begin
		if (half_q) begin
			wr.out_byte = b & ESC_MASK;
			wr.run_last = op_data.last;
			wr.frame_end = (op_data.kind == OP_CRCL);
			wr.error = 1'b0;
		end else if (need_esc) begin
			wr.out_byte = ESC_BYTE;
			wr.run_last = 1'b0;
			wr.frame_end = 1'b0;
			wr.error = 1'b0;
		end else begin
			wr.out_byte = b;
			wr.run_last = op_data.last;
			wr.frame_end = (op_data.kind == OP_CRCL);
			wr.error = (op_data.kind == OP_ERR);
		end
	end

	// CRC and escape phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			half_q <= 1'b0;
		end else if (go) begin
			half_q <= !half_q && need_esc;
			if (!half_q) begin
				if (op_data.kind == OP_START) begin
					crc_q <= crc_feed(CRC_INIT, SOF_BYTE);
				end else if (op_data.kind == OP_DATA) begin
					crc_q <= crc_feed(crc_q, b);
				end
			end
		end
	end

	// Result queue pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (go) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (out_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({go, out_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (go) begin
			mem_q[wptr_q] <= wr;
		end
	end

	assign res_empty = (cnt_q == '0);
	assign res = mem_q[rptr_q];

endmodule
`default_nettype wire

// ===== src/radio_frame_encoder_crc_escape_core.sv =====
// The first result of an item passes the front end's step register, the job queue and
// the result queue before it is shown. The back end writes one line byte per cycle
// while a job waits and the result queue has room; an item gives 1 to 15 line bytes
// for a header, 0 to 6 for a payload byte. The front end takes a new item in the cycle
// its previous item's last job is queued. Reset (arst_n low, asynchronous) empties both
// queues, closes any frame and sets the size limit to 65535; no clearing pass follows.
`default_nettype none
module radio_frame_encoder_crc_escape_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        max_frame_bytes_we,
	input  wire logic [15:0] max_frame_bytes,
	input  wire logic        push,
	output logic             full,
	input  wire logic        cmd,
	input  wire logic [7:0]  destination,
	input  wire logic [7:0]  sequence_count,
	input  wire logic [7:0]  command_code,
	input  wire logic [15:0] payload_length,
	input  wire logic        escape_enable,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             frame_end,
	output logic             error
);
	import rfe_pkg::*;

	op_t  fr_op;
	op_t  bk_op;
	logic fr_push;
	logic q_full;
	logic q_empty;
	logic bk_pop;
	res_t res;

	// Front end: takes items, tracks the frame and issues byte jobs.
	rfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (max_frame_bytes_we),
		.cfg_data       (max_frame_bytes),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.destination    (destination),
		.sequence_count (sequence_count),
		.command_code   (command_code),
		.payload_length (payload_length),
		.escape_enable  (escape_enable),
		.data_byte      (data_byte),
		.op_push        (fr_push),
		.op_full        (q_full),
		.op_data        (fr_op)
	);

	// Job queue between the two ends.
	rfe_op_queue u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_push),
		.push_data (fr_op),
		.full      (q_full),
		.pop       (bk_pop),
		.pop_data  (bk_op),
		.empty     (q_empty)
	);

	// Back end: CRC, escaping and the result queue.
	rfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_empty  (q_empty),
		.op_data   (bk_op),
		.op_pop    (bk_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	assign out_byte = res.out_byte;
	assign run_last = res.run_last;
	assign frame_end = res.frame_end;
	assign error = res.error;

`ifndef NO_ASSERTIONS
	// The final frame byte always closes the item that caused it.
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> run_last)
		else $error("frame_end without run_last");

	// A rejection is a single result with no line byte.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error) |-> (run_last && !frame_end && out_byte == 8'h00))
		else $error("malformed error result");

	// A job is never taken from an empty queue.
	a_pop_guard: assert property (@(posedge clk) disable iff (!arst_n)
		bk_pop |-> !q_empty)
		else $error("job popped from empty queue");
`endif

endmodule
`default_nettype wire
